### rtl/core/bdq_pkg.sv
package bdq_pkg;

	// capacity and derived widths
	localparam int DEPTH  = 8;
	localparam int WORD_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OCC_W  = 4;

	// operation codes
	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_BACK   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVER  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// request transaction
	typedef struct packed {
		logic [1:0]               operation;
		logic signed [WORD_W-1:0] value;
	} bdq_req_t;

	// result transaction
	typedef struct packed {
		logic signed [WORD_W-1:0] popped;
		logic [1:0]               status;
		logic [OCC_W-1:0]         occupancy;
	} bdq_rsp_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic capture;
	} bdq_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic need_read;
	} bdq_stat_t;

endpackage

### rtl/core/bounded_deque.sv
// bounded double-ended queue of signed 32-bit words, capacity DEPTH
//
// request channel: drive req (operation, value) and raise start; the
// transaction is taken at a rising edge where start is high and busy low.
// result channel: done is high for exactly one cycle while rsp carries the
// popped word, the status (ok, overflow, empty) and the occupancy after the
// operation; the receiver cannot hold a result off.
//
// a push or a rejected pop is done after the execute state; a successful
// pop also passes through the read state, which waits for the registered
// read of the single-port entry store. one operation is in flight at a
// time, so a new transaction is taken only after the previous result;
// start may be held high during the result cycle and is taken then.
//
// reset clears the head pointer and fill count, leaving the queue empty;
// store contents are not cleared and are only read after being written.
module bounded_deque
	import bdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  bdq_req_t req,
	output logic     busy,
	output logic     done,
	output bdq_rsp_t rsp
);

	bdq_cmd_t  cmd;
	bdq_stat_t stat;

	// sequencing
	bdq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// pointers, store and result register
	bdq_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.stat  (stat),
		.rsp   (rsp)
	);

endmodule

### rtl/core/bdq_ram.sv
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                  wdata,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/bdq_ctrl.sv
module bdq_ctrl
	import bdq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  bdq_stat_t stat,
	output bdq_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       done_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.need_read) begin
					state_d = S_READ;
				end else begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			S_READ: begin
				cmd.capture = 1'b1;
				state_d     = S_IDLE;
				done_d      = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

### rtl/core/bdq_dp.sv
module bdq_dp
	import bdq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  bdq_cmd_t  cmd,
	input  bdq_req_t  req,
	output bdq_stat_t stat,
	output bdq_rsp_t  rsp
);

	localparam int AW1 = ADDR_W + 1;
	localparam logic [ADDR_W:0]   DEPTH_X = AW1'(DEPTH);
	localparam logic [ADDR_W-1:0] LAST    = ADDR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_C  = CNT_W'(DEPTH);

	bdq_req_t          req_q;
	bdq_rsp_t          rsp_q;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;

	logic              is_push;
	logic              full;
	logic              empty;
	logic              reject;
	logic [ADDR_W-1:0] head_dec;
	logic [ADDR_W-1:0] head_inc;
	logic [ADDR_W-1:0] offset;
	logic [ADDR_W:0]   sum;
	logic [ADDR_W-1:0] wrapped;
	logic [ADDR_W-1:0] slot;
	logic [ADDR_W-1:0] head_d;
	logic [CNT_W-1:0]  count_d;
	logic [1:0]        status_d;
	logic              ram_we;
	logic [WORD_W-1:0] ram_rdata;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// occupancy tests
	assign is_push = req_q.operation inside {OP_PUSH_FRONT, OP_PUSH_BACK};
	assign full    = (count_q == FULL_C);
	assign empty   = (count_q == '0);
	assign reject  = is_push ? full : empty;
	assign stat.need_read = !is_push && !empty;

	// circular pointer arithmetic
	assign head_dec = (head_q == '0) ? LAST : head_q - ADDR_W'(1);
	assign head_inc = (head_q == LAST) ? '0 : head_q + ADDR_W'(1);

	always_comb begin
		case (req_q.operation)
			OP_PUSH_BACK: offset = ADDR_W'(count_q);
			OP_POP_BACK:  offset = ADDR_W'(count_q - CNT_W'(1));
			default:      offset = '0;
		endcase
	end

	assign sum     = {1'b0, head_q} + {1'b0, offset};
	assign wrapped = (sum >= DEPTH_X) ? ADDR_W'(sum - DEPTH_X) : ADDR_W'(sum);

	// slot addressed by this operation
	always_comb begin
		case (req_q.operation)
			OP_PUSH_FRONT: slot = head_dec;
			OP_POP_FRONT:  slot = head_q;
			default:       slot = wrapped;
		endcase
	end

	// pointer and count update
	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = ST_OK;
		if (reject) begin
			status_d = is_push ? ST_OVER : ST_EMPTY;
		end else if (is_push) begin
			count_d = count_q + CNT_W'(1);
			if (req_q.operation == OP_PUSH_FRONT) begin
				head_d = head_dec;
			end
		end else begin
			count_d = count_q - CNT_W'(1);
			if (req_q.operation == OP_POP_FRONT) begin
				head_d = head_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// entry store
	assign ram_we = cmd.exec && is_push && !reject;

	bdq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (slot),
		.wdata(req_q.value),
		.rdata(ram_rdata)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.popped    <= '0;
			rsp_q.status    <= status_d;
			rsp_q.occupancy <= OCC_W'(count_d);
		end else if (cmd.capture) begin
			rsp_q.popped <= ram_rdata;
		end
	end

	assign rsp = rsp_q;

endmodule

### rtl/core/bdq_chk.sv
module bdq_chk
	import bdq_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input bdq_rsp_t rsp
);

	// an accepted transaction holds the block busy for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not make the block busy");

	// the result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// the block goes idle exactly when a result appears
	a_idle_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("block went idle without a result");

	// rejected operations return no word
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == ST_OVER || rsp.status == ST_EMPTY) |-> rsp.popped == '0)
		else $error("rejected operation returned a word");

	// only defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_OVER || rsp.status == ST_EMPTY))
		else $error("undefined status code");

endmodule

bind bounded_deque bdq_chk u_bdq_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);
